[rtl/core/sgt_pkg.sv]
// Shared constants and types for the sync signal gap translator.
package sgt_pkg;

	localparam int NUM_ENGINES  = 4;
	localparam int MAX_GAPS     = 64;
	localparam int TPC_SET_SIZE = 32;

	localparam logic [31:0] SET_BITS     = 32'h0000_E000;
	localparam logic [31:0] K0_THRESH    = 32'h0000_7FE0;
	localparam logic [31:0] K0_LOW_BIT   = 32'h0000_0020;
	localparam logic [31:0] K2_THRESH    = 32'h0000_7FFF;
	localparam logic [31:0] LIMIT_RESET  = 32'h0000_FFFF;

	localparam int IN_DATA_W  = 184;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 200;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		ENG_TENSOR = 2'd0,
		ENG_MATRIX = 2'd1,
		ENG_DMA    = 2'd2,
		ENG_ROT    = 2'd3
	} engine_t;

	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_OVER_LIMIT = 3'd1,
		ERR_BAD_COUNT  = 3'd2,
		ERR_TABLE_FULL = 3'd3,
		ERR_ZERO_VALUE = 3'd4
	} err_t;

	localparam logic MODE_ISSUE   = 1'b0;
	localparam logic MODE_REVERSE = 1'b1;

endpackage

[rtl/core/sgt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module sgt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/sync_signal_gap_translator.sv]
// Top level of the sync signal gap translator: counters, sequencer and gap table search.
//
// Items enter on the s_ channel (s_tuser carries mode and engine) and leave on the
// m_ channel, one result per item. The cfg channel writes the signal limit and is
// always ready; the user must write it only while the block is idle, which the
// block does not enforce. An issue item updates the engine counter and gap table in
// its accept cycle, then each present dependency searches its engine's gap table
// from the newest entry backward, with an ST_SRCH and an ST_CMP step per entry read
// from the gap table RAM and an ST_NEXT step per dependency slot. A reverse item
// searches once. Items rejected at acceptance (bad count, full table, zero value)
// skip the search; the others read entries one at a time through the single read
// port. One item is worked on at a time; the next is accepted once the result is
// loaded into the output register, so the block takes it while the result waits; a
// stalled receiver holds that register and the sequencer waits before overwriting it.
// Reset clears the counters, sets the fill counts to 1 and the limit to 65535. The
// table RAM needs no clearing: only entries below the fill count are ever read.
module sync_signal_gap_translator
	import sgt_pkg::*;
#(
	parameter int MAX_GAPS_P = sgt_pkg::MAX_GAPS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// signal_count, dep_mask, dep_index_tpc, dep_index_mme, dep_index_dma,
	// dep_index_rot, physical_value, zero fill
	input  logic [sgt_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode, engine
	input  logic [sgt_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// emitted_signal, wait_mask, wait_tpc, wait_mme, wait_dma, wait_rot,
	// logical_index, error_code, zero fill
	output logic [sgt_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [31:0]                    cfg_data
);
	localparam int IW = $clog2(MAX_GAPS_P);
	localparam int UW = $clog2(MAX_GAPS_P + 1);
	localparam int AW = 2 + IW;

	typedef enum logic [2:0] {ST_IDLE, ST_NEXT, ST_SRCH, ST_CMP, ST_DONE} state_t;

	state_t        state_q;
	word_t         limit_q;
	word_t         phys_q [NUM_ENGINES];
	word_t         logc_q [NUM_ENGINES];
	word_t         loff_q [NUM_ENGINES];
	logic [UW-1:0] used_q [NUM_ENGINES];

	logic          mode_q;
	logic [3:0]    mask_q;
	word_t         idx_q [NUM_ENGINES];
	word_t         key_q;
	logic [1:0]    dep_q;
	logic [1:0]    seng_q;
	logic [UW-1:0] i_q;
	word_t         emit_q;
	word_t         wait_q [NUM_ENGINES];
	word_t         lidx_q;
	err_t          err_q;
	logic          mvalid_q;
	logic [OUT_DATA_W-1:0] mdata_q;

	logic          in_mode;
	logic [1:0]    in_eng;
	logic [12:0]   in_cnt;
	word_t         in_idx [NUM_ENGINES];
	word_t         in_pv;
	logic          accept;
	word_t         old_c, nsum, nv, gap, v;
	word_t         n32;
	logic          bad_cnt, full;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;
	word_t         rd_start, rd_off, bound, found_off, w;
	logic          out_free;

	assign in_mode   = s_tuser[0];
	assign in_eng    = s_tuser[2:1];
	assign in_cnt    = s_tdata[12:0];
	assign in_idx[0] = s_tdata[48:17];
	assign in_idx[1] = s_tdata[80:49];
	assign in_idx[2] = s_tdata[112:81];
	assign in_idx[3] = s_tdata[144:113];
	assign in_pv     = s_tdata[176:145];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = mvalid_q;
	assign m_tdata   = mdata_q;
	assign out_free  = !mvalid_q || m_tready;

	always_comb begin
		old_c   = phys_q[in_eng];
		n32     = {19'd0, in_cnt};
		nsum    = old_c + n32;
		bad_cnt = (in_eng != ENG_MATRIX) && (in_cnt > 13'd1);
		v       = nsum;
		nv      = nsum;
		if (in_cnt == 13'd0) begin
			nv = old_c;
		end else if (in_eng == ENG_TENSOR) begin
			if (old_c == 32'd0) begin
				nv = 32'(TPC_SET_SIZE);
			end else if ((v & K0_THRESH) == 32'd0) begin
				nv = v | K0_LOW_BIT;
			end
		end else if (in_eng == ENG_DMA) begin
			if ((v & K2_THRESH) == 32'd0) begin
				nv = v | 32'd1;
			end
		end else if ((old_c & SET_BITS) != (v & SET_BITS)) begin
			nv = (v & SET_BITS) + n32;
		end
		gap  = nv - nsum;
		full = (used_q[in_eng] >= UW'(MAX_GAPS_P));
	end

	assign ram_we    = accept && (in_mode == MODE_ISSUE) && !bad_cnt && (gap != 32'd0) && !full;
	assign ram_waddr = {in_eng, used_q[in_eng][IW-1:0]};
	assign ram_wdata = {loff_q[in_eng] + gap, logc_q[in_eng]};
	assign ram_raddr = {seng_q, IW'(i_q - UW'(1))};

	sgt_ram #(
		.WIDTH(64),
		.DEPTH(NUM_ENGINES << IW)
	) u_gap_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		rd_start  = ram_rdata[31:0];
		rd_off    = ram_rdata[63:32];
		bound     = mode_q ? (rd_start + rd_off) : rd_start;
		found_off = (state_q == ST_CMP) ? rd_off : 32'd0;
		w         = key_q + found_off + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			limit_q  <= LIMIT_RESET;
			mvalid_q <= 1'b0;
			for (int k = 0; k < NUM_ENGINES; k++) begin
				phys_q[k] <= '0;
				logc_q[k] <= '0;
				loff_q[k] <= '0;
				used_q[k] <= UW'(1);
			end
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (mvalid_q && m_tready && state_q != ST_DONE) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= in_mode;
						dep_q  <= 2'd0;
						lidx_q <= '0;
						emit_q <= '0;
						err_q  <= ERR_OK;
						for (int k = 0; k < NUM_ENGINES; k++) begin
							wait_q[k] <= '0;
							idx_q[k]  <= in_idx[k];
						end
						if (in_mode == MODE_REVERSE) begin
							mask_q <= 4'd0;
							key_q  <= in_pv - 32'd1;
							seng_q <= in_eng;
							i_q    <= used_q[in_eng];
							if (in_pv == 32'd0) begin
								err_q   <= ERR_ZERO_VALUE;
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_SRCH;
							end
						end else begin
							mask_q <= s_tdata[16:13];
							if (bad_cnt) begin
								emit_q  <= old_c;
								err_q   <= ERR_BAD_COUNT;
								state_q <= ST_DONE;
							end else if ((gap != 32'd0) && full) begin
								emit_q  <= old_c;
								err_q   <= ERR_TABLE_FULL;
								state_q <= ST_DONE;
							end else begin
								if (gap != 32'd0) begin
									loff_q[in_eng] <= loff_q[in_eng] + gap;
									used_q[in_eng] <= used_q[in_eng] + UW'(1);
								end
								phys_q[in_eng] <= nv;
								logc_q[in_eng] <= logc_q[in_eng] + n32;
								emit_q <= nv;
								if (nv > limit_q) begin
									err_q <= ERR_OVER_LIMIT;
								end
								state_q <= ST_NEXT;
							end
						end
					end
				end
				ST_NEXT: begin
					if (mask_q[dep_q]) begin
						key_q   <= idx_q[dep_q];
						seng_q  <= dep_q;
						i_q     <= used_q[dep_q];
						state_q <= ST_SRCH;
					end else if (dep_q == 2'd3) begin
						state_q <= ST_DONE;
					end else begin
						dep_q <= dep_q + 2'd1;
					end
				end
				ST_SRCH, ST_CMP: begin
					if (state_q == ST_SRCH && i_q > UW'(1)) begin
						state_q <= ST_CMP;
					end else if (state_q == ST_CMP && key_q < bound) begin
						i_q     <= i_q - UW'(1);
						state_q <= ST_SRCH;
					end else if (mode_q == MODE_REVERSE) begin
						lidx_q  <= key_q - found_off;
						state_q <= ST_DONE;
					end else begin
						wait_q[dep_q] <= w;
						if (w > limit_q) begin
							err_q <= ERR_OVER_LIMIT;
						end
						if (dep_q == 2'd3) begin
							state_q <= ST_DONE;
						end else begin
							dep_q   <= dep_q + 2'd1;
							state_q <= ST_NEXT;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						mdata_q  <= {1'b0, err_q, lidx_q, wait_q[3], wait_q[2], wait_q[1],
							wait_q[0], mask_q, emit_q};
						mvalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("Second item accepted while one is in progress.");
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> accept)
		else $error("Gap table written outside an accepted item.");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q[0] <= UW'(MAX_GAPS_P)) && (used_q[1] <= UW'(MAX_GAPS_P)) &&
		(used_q[2] <= UW'(MAX_GAPS_P)) && (used_q[3] <= UW'(MAX_GAPS_P)))
		else $error("Gap table fill count beyond its depth.");
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q |-> (mdata_q[198:196] <= 3'd4))
		else $error("Result carries an undefined error code.");

endmodule
